@@ rtl/rpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position rotate package
// Shared constants, types and the build-time tables for the rotary position
// rotate block: inverse frequencies, CORDIC angles and the CORDIC gain.
// ----------------------------------------------------------------------------
package rpr_pkg;

   // Block configuration.
   localparam int HEAD_DIM      = 128;
   localparam int MAX_POSITION  = 4096;
   localparam int CORDIC_STAGES = 16;
   localparam int PAIRS         = HEAD_DIM / 2;

   // Field widths.
   localparam int POS_W    = 12;
   localparam int PAIR_W   = 6;
   localparam int SAMPLE_W = 16;

   // Internal datapath widths.
   localparam int GUARD_BITS  = 14;
   localparam int DATA_W      = 32;
   localparam int PHASE_W     = 32;
   localparam int GAIN_FRAC   = 30;
   localparam int ROUND_SHIFT = GAIN_FRAC + GUARD_BITS;
   localparam int IDX_W       = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int SHIFT_W     = $clog2(CORDIC_STAGES);

   // Fixed-point constants.
   localparam logic [63:0] LOG2_THETA_Q32 = 64'd57070290109;
   localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

   // Quarter turn applied ahead of the CORDIC chain.
   typedef enum logic [1:0] {
      QUARTER_NONE  = 2'd0,
      QUARTER_LEFT  = 2'd1,
      QUARTER_HALF  = 2'd2,
      QUARTER_RIGHT = 2'd3
   } quarter_type;

   // One request in flight through a rotation stage.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } rot_type;

   typedef logic [PHASE_W-1:0]        freq_table_type [PAIRS];
   typedef logic signed [DATA_W-1:0]  atan_table_type [CORDIC_STAGES];

   // Truncating integer square root, two bits per step.
   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bit_v;
      v     = value;
      r     = 64'd0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bit_v > v) begin
            bit_v = bit_v >> 2;
         end
      end
      for (int j = 0; j < 32; j++) begin
         if (bit_v != 64'd0) begin
            if (v >= r + bit_v) begin
               v = v - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // Restoring long division, one quotient bit per step.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int j = 63; j >= 0; j--) begin
         rem = {rem[62:0], num[j]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[j] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Inverse frequencies in Q0.32 turns per position.
   function automatic freq_table_type build_freq_table();
      freq_table_type t;
      logic [63:0]    ladder [32];
      logic [63:0]    e;
      logic [63:0]    whole;
      logic [63:0]    r;
      logic [127:0]   prod;
      ladder[0] = isqrt64(64'd1 << 63);
      for (int b = 1; b < 32; b++) begin
         ladder[b] = isqrt64(ladder[b-1] << 32);
      end
      for (int k = 0; k < PAIRS; k++) begin
         e     = (64'(2 * k) * LOG2_THETA_Q32) / 64'(HEAD_DIM);
         whole = e >> 32;
         r     = 64'd1 << 32;
         for (int b = 1; b <= 32; b++) begin
            if (e[32-b]) begin
               prod = 128'(r) * 128'(ladder[b-1]);
               r    = prod[95:32];
            end
         end
         r    = (whole < 64'd63) ? (r >> whole) : 64'd0;
         prod = 128'(r) * 128'(INV_TWO_PI_Q32) + (128'd1 << 31);
         t[k] = prod[63:32];
      end
      return t;
   endfunction

   // CORDIC step angles atan(2^-i) in Q0.32 turns.
   function automatic atan_table_type build_atan_table();
      atan_table_type     a;
      logic signed [63:0] sum;
      logic signed [63:0] term;
      logic [63:0]        rad;
      logic [127:0]       prod;
      int                 sh;
      a[0] = 32'sh2000_0000;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         sum = 64'sd0;
         for (int n = 0; n < 32; n++) begin
            sh = 62 - i * (2 * n + 1);
            if (sh >= 0) begin
               term = $signed(udiv64(64'd1 << sh, 64'(2 * n + 1)));
               if ((n & 1) != 0) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         rad  = ($unsigned(sum) + (64'd1 << 29)) >> 30;
         prod = 128'(rad) * 128'(INV_TWO_PI_Q32) + (128'd1 << 31);
         a[i] = $signed(prod[63:32]);
      end
      return a;
   endfunction

   // Product of the CORDIC stage gains' inverses in Q2.30.
   function automatic logic signed [DATA_W-1:0] build_gain();
      logic [63:0] g;
      logic [63:0] arg;
      logic [63:0] s;
      g = 64'd1 << 30;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         arg = (64'd1 << 30) + ((30 - 2 * i >= 0) ? (64'd1 << (30 - 2 * i)) : 64'd0);
         s   = isqrt64(arg << 30);
         g   = udiv64(g << 30, s);
      end
      return $signed(g[DATA_W-1:0]);
   endfunction

   localparam freq_table_type           INV_FREQ_TABLE = build_freq_table();
   localparam atan_table_type           ATAN_TABLE     = build_atan_table();
   localparam logic signed [DATA_W-1:0] CORDIC_GAIN    = build_gain();

endpackage

@@ rtl/rotary_position_rotate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position rotate
// Turns one activation pair by position times its inverse frequency using a
// chain of CORDIC cells, with gain compensation and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries a token position, a pair index and a Q4.12 pair
//   (real, imaginary). The response carries the rotated pair in Q4.12.
//   Both channels use valid/ready; one response is returned per request,
//   in request order.
//   A request passes from acceptance to response valid through
//   21 register stages: table lookup, phase multiply, quarter-turn step,
//   16 CORDIC cells, gain multiply and the round/saturate response register.
//   Throughput without receiver stalls is one request per cycle; every
//   stage is a register with its own valid bit; the cells set latency, not rate.
//   When the receiver stalls, requests keep flowing into empty stages until
//   the pipeline is full, after which req_ready drops; nothing is lost.
//   Reset empties every stage; the frequency and angle tables are constants
//   and need no initialization time.
// ----------------------------------------------------------------------------
module rotary_position_rotate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rpr_pkg::POS_W-1:0]            req_position,
   input  logic [rpr_pkg::PAIR_W-1:0]           req_pair_index,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_real_in,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_imag_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  rsp_real_out,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  rsp_imag_out
);

   localparam int DW = rpr_pkg::DATA_W;
   localparam int CS = rpr_pkg::CORDIC_STAGES;
   localparam logic [rpr_pkg::POS_W-1:0] POS_LAST = rpr_pkg::POS_W'(rpr_pkg::MAX_POSITION - 1);
   localparam logic [rpr_pkg::IDX_W-1:0] IDX_LAST = rpr_pkg::IDX_W'(rpr_pkg::PAIRS - 1);

   // Lookup stage.
   logic                                f1_valid_ff;
   logic [rpr_pkg::POS_W-1:0]           f1_pos_ff, f1_pos_in;
   logic [rpr_pkg::PHASE_W-1:0]         f1_freq_ff;
   logic signed [rpr_pkg::SAMPLE_W-1:0] f1_real_ff;
   logic signed [rpr_pkg::SAMPLE_W-1:0] f1_imag_ff;
   logic [rpr_pkg::IDX_W-1:0]           f1_idx_in;
   logic                                f1_ready;

   // Phase stage.
   logic                                f2_valid_ff;
   logic [rpr_pkg::PHASE_W-1:0]         f2_phase_ff;
   logic [rpr_pkg::PHASE_W-1:0]         f2_phase_in;
   logic [rpr_pkg::POS_W+rpr_pkg::PHASE_W-1:0] f2_product;
   logic signed [rpr_pkg::SAMPLE_W-1:0] f2_real_ff;
   logic signed [rpr_pkg::SAMPLE_W-1:0] f2_imag_ff;
   logic                                f2_ready;

   // Quarter-turn stage feeding the first cell.
   logic                                f3_valid_ff;
   logic signed [DW-1:0]                f3_x_ff, f3_x_in;
   logic signed [DW-1:0]                f3_y_ff, f3_y_in;
   logic signed [DW-1:0]                f3_z_ff, f3_z_in;
   logic [rpr_pkg::PHASE_W:0]           phase_round;
   rpr_pkg::quarter_type                quarter;
   logic signed [DW-1:0]                real_ext;
   logic signed [DW-1:0]                imag_ext;
   logic                                f3_ready;

   rpr_pkg::rot_type                    stage_chain [CS+1];
   logic                                stage_ready [CS+1];

   // Clamp position and pair index into the table range.
   always_comb begin
      if ({{(32-rpr_pkg::POS_W){1'b0}}, req_position} >= 32'(rpr_pkg::MAX_POSITION)) begin
         f1_pos_in = POS_LAST;
      end else begin
         f1_pos_in = req_position;
      end
      if ({{(32-rpr_pkg::PAIR_W){1'b0}}, req_pair_index} >= 32'(rpr_pkg::PAIRS)) begin
         f1_idx_in = IDX_LAST;
      end else begin
         f1_idx_in = rpr_pkg::IDX_W'(req_pair_index);
      end
   end

   // Stall chain of the front stages.
   assign f3_ready  = !f3_valid_ff || stage_ready[0];
   assign f2_ready  = !f2_valid_ff || f3_ready;
   assign f1_ready  = !f1_valid_ff || f2_ready;
   assign req_ready = f1_ready;

   // Phase in fractional turns; whole turns fall off the top.
   assign f2_product  = {{rpr_pkg::PHASE_W{1'b0}}, f1_pos_ff} *
                        {{rpr_pkg::POS_W{1'b0}}, f1_freq_ff};
   assign f2_phase_in = f2_product[rpr_pkg::PHASE_W-1:0];

   // Nearest quarter turn applied exactly; the residual goes to the cells.
   always_comb begin
      phase_round = {1'b0, f2_phase_ff} + (33'd1 << 29);
      quarter     = rpr_pkg::quarter_type'(phase_round[31:30]);
      f3_z_in     = $signed(f2_phase_ff - {phase_round[31:30], 30'd0});
      real_ext    = $signed({{(DW-rpr_pkg::SAMPLE_W){f2_real_ff[rpr_pkg::SAMPLE_W-1]}},
                             f2_real_ff}) <<< rpr_pkg::GUARD_BITS;
      imag_ext    = $signed({{(DW-rpr_pkg::SAMPLE_W){f2_imag_ff[rpr_pkg::SAMPLE_W-1]}},
                             f2_imag_ff}) <<< rpr_pkg::GUARD_BITS;
      unique case (quarter)
         rpr_pkg::QUARTER_NONE: begin
            f3_x_in = real_ext;
            f3_y_in = imag_ext;
         end
         rpr_pkg::QUARTER_LEFT: begin
            f3_x_in = -imag_ext;
            f3_y_in = real_ext;
         end
         rpr_pkg::QUARTER_HALF: begin
            f3_x_in = -real_ext;
            f3_y_in = -imag_ext;
         end
         rpr_pkg::QUARTER_RIGHT: begin
            f3_x_in = imag_ext;
            f3_y_in = -real_ext;
         end
         default: begin
            f3_x_in = real_ext;
            f3_y_in = imag_ext;
         end
      endcase
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         if (f1_ready) begin
            f1_valid_ff <= req_valid;
         end
         if (f2_ready) begin
            f2_valid_ff <= f1_valid_ff;
         end
         if (f3_ready) begin
            f3_valid_ff <= f2_valid_ff;
         end
      end
   end

   // Data registers of the front stages.
   always_ff @(posedge clock) begin
      if (f1_ready) begin
         f1_pos_ff  <= f1_pos_in;
         f1_freq_ff <= rpr_pkg::INV_FREQ_TABLE[f1_idx_in];
         f1_real_ff <= req_real_in;
         f1_imag_ff <= req_imag_in;
      end
      if (f2_ready) begin
         f2_phase_ff <= f2_phase_in;
         f2_real_ff  <= f1_real_ff;
         f2_imag_ff  <= f1_imag_ff;
      end
      if (f3_ready) begin
         f3_x_ff <= f3_x_in;
         f3_y_ff <= f3_y_in;
         f3_z_ff <= f3_z_in;
      end
   end

   assign stage_chain[0] = '{valid: f3_valid_ff, x: f3_x_ff, y: f3_y_ff, z: f3_z_ff};

   // Chain of CORDIC cells, one micro-rotation each.
   for (genvar i = 0; i < CS; i++) begin : g_cell
      rpr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (rpr_pkg::SHIFT_W'(i)),
         .angle     (rpr_pkg::ATAN_TABLE[i]),
         .prev      (stage_chain[i]),
         .ready_in  (stage_ready[i+1]),
         .ready_out (stage_ready[i]),
         .next      (stage_chain[i+1])
      );
   end

   // Gain compensation and response register.
   rpr_gain u_gain (
      .clock        (clock),
      .reset        (reset),
      .rot_in       (stage_chain[CS]),
      .ready_out    (stage_ready[CS]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_real_out (rsp_real_out),
      .rsp_imag_out (rsp_imag_out)
   );

   // An accepted request always lands in the lookup stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> f1_valid_ff)
      else $error("accepted request did not enter the lookup stage");

   // A stalled lookup stage keeps its request.
   assert property (@(posedge clock) disable iff (reset)
      f1_valid_ff && !f2_ready |=> f1_valid_ff && $stable(f1_pos_ff) && $stable(f1_freq_ff))
      else $error("lookup stage lost a stalled request");

   // The residual angle after the quarter turn stays within one eighth turn.
   assert property (@(posedge clock) disable iff (reset)
      f3_valid_ff |-> (f3_z_ff >= -(32'sd1 <<< 29)) && (f3_z_ff <= (32'sd1 <<< 29)))
      else $error("residual angle out of range");

   // No response is presented right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ rtl/rpr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position rotate CORDIC cell
// One micro-rotation of the CORDIC chain with its own pipeline register and
// a hold when the following cell cannot take the request.
// ----------------------------------------------------------------------------
module rpr_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rpr_pkg::SHIFT_W-1:0]         shift_amt,
   input  logic signed [rpr_pkg::DATA_W-1:0]   angle,
   input  rpr_pkg::rot_type                    prev,
   input  logic                                ready_in,
   output logic                                ready_out,
   output rpr_pkg::rot_type                    next
);

   logic                              valid_ff;
   logic signed [rpr_pkg::DATA_W-1:0] x_ff, x_in;
   logic signed [rpr_pkg::DATA_W-1:0] y_ff, y_in;
   logic signed [rpr_pkg::DATA_W-1:0] z_ff, z_in;
   logic signed [rpr_pkg::DATA_W-1:0] dx;
   logic signed [rpr_pkg::DATA_W-1:0] dy;

   // The cell takes a new request when empty or when its own moves on.
   assign ready_out = !valid_ff || ready_in;

   // Rotate toward a zero residual angle; the shift rounds toward minus infinity.
   always_comb begin
      dx = $signed(prev.y) >>> shift_amt;
      dy = $signed(prev.x) >>> shift_amt;
      if (!prev.z[rpr_pkg::DATA_W-1]) begin
         x_in = $signed(prev.x) - dx;
         y_in = $signed(prev.y) + dy;
         z_in = $signed(prev.z) - angle;
      end else begin
         x_in = $signed(prev.x) + dx;
         y_in = $signed(prev.y) - dy;
         z_in = $signed(prev.z) + angle;
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= prev.valid;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (ready_out) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign next = '{valid: valid_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

@@ rtl/rpr_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position rotate gain stage
// Removes the CORDIC gain, drops the guard bits with rounding, saturates to
// 16 bits and holds the response register.
// ----------------------------------------------------------------------------
module rpr_gain (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rpr_pkg::rot_type                      rot_in,
   output logic                                  ready_out,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]   rsp_real_out,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]   rsp_imag_out
);

   localparam int PROD_W = 2 * rpr_pkg::DATA_W;

   logic                              prod_valid_ff;
   logic signed [PROD_W-1:0]          prod_x_ff;
   logic signed [PROD_W-1:0]          prod_y_ff;
   logic                              out_valid_ff;
   logic signed [rpr_pkg::SAMPLE_W-1:0] real_ff, real_in;
   logic signed [rpr_pkg::SAMPLE_W-1:0] imag_ff, imag_in;
   logic                              prod_ready;
   logic                              out_ready;
   logic signed [PROD_W-1:0]          round_x;
   logic signed [PROD_W-1:0]          round_y;
   logic signed [PROD_W-1:0]          shift_x;
   logic signed [PROD_W-1:0]          shift_y;

   localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) <<< (rpr_pkg::ROUND_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

   // Stall chain from the response register back to the multiplier stage.
   assign out_ready  = !out_valid_ff || rsp_ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign ready_out  = prod_ready;

   // Round to nearest, then saturate.
   always_comb begin
      round_x = prod_x_ff + HALF;
      round_y = prod_y_ff + HALF;
      shift_x = round_x >>> rpr_pkg::ROUND_SHIFT;
      shift_y = round_y >>> rpr_pkg::ROUND_SHIFT;
      if (shift_x > SAT_HI) begin
         real_in = 16'sh7fff;
      end else if (shift_x < SAT_LO) begin
         real_in = 16'sh8000;
      end else begin
         real_in = shift_x[rpr_pkg::SAMPLE_W-1:0];
      end
      if (shift_y > SAT_HI) begin
         imag_in = 16'sh7fff;
      end else if (shift_y < SAT_LO) begin
         imag_in = 16'sh8000;
      end else begin
         imag_in = shift_y[rpr_pkg::SAMPLE_W-1:0];
      end
   end

   // Valid bits of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= rot_in.valid;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   // Gain multiply and response registers.
   always_ff @(posedge clock) begin
      if (prod_ready) begin
         prod_x_ff <= $signed(rot_in.x) * rpr_pkg::CORDIC_GAIN;
         prod_y_ff <= $signed(rot_in.y) * rpr_pkg::CORDIC_GAIN;
      end
      if (out_ready) begin
         real_ff <= real_in;
         imag_ff <= imag_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_real_out = real_ff;
   assign rsp_imag_out = imag_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position rotate testbench
// Streams directed and random requests through the rotate pipeline. The
// sender idles in bursts and the receiver stalls on its own pattern, with
// one long hold-off that fills the pipeline. Every response is checked,
// field by field and in order, against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

   // Block geometry and fixed-point format of the rotation.
   localparam int HEAD_SIZE     = 128;
   localparam int PAIR_COUNT    = HEAD_SIZE / 2;
   localparam int POSITION_SPAN = 4096;
   localparam int STAGES        = 16;
   localparam int GUARD         = 14;
   localparam int GAIN_BITS     = 30;
   localparam longint unsigned LOG2_THETA = 64'd57070290109;  // log2(10000), Q.32
   localparam longint unsigned TURN_SCALE = 64'd683565276;    // 1/(2 pi), Q0.32

   // Run control.
   localparam int RANDOM_REQS  = 1850;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 150;
   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [rpr_pkg::POS_W-1:0]           position;
      logic [rpr_pkg::PAIR_W-1:0]          pair_index;
      logic signed [rpr_pkg::SAMPLE_W-1:0] re;
      logic signed [rpr_pkg::SAMPLE_W-1:0] im;
   } rotate_req_type;

   typedef struct packed {
      logic signed [rpr_pkg::SAMPLE_W-1:0] re;
      logic signed [rpr_pkg::SAMPLE_W-1:0] im;
   } rotated_pair_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_HALF,
      RX_SPARSE,
      RX_TOGGLE
   } rx_mode_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [rpr_pkg::POS_W-1:0]           req_position = '0;
   logic [rpr_pkg::PAIR_W-1:0]          req_pair_index = '0;
   logic signed [rpr_pkg::SAMPLE_W-1:0] req_real_in = '0;
   logic signed [rpr_pkg::SAMPLE_W-1:0] req_imag_in = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [rpr_pkg::SAMPLE_W-1:0] rsp_real_out;
   logic signed [rpr_pkg::SAMPLE_W-1:0] rsp_imag_out;

   // Predictor tables, built once at time zero.
   logic [31:0]   freq_turns [PAIR_COUNT];
   longint        step_angle [STAGES];
   longint        cordic_gain;

   rotate_req_type   pending_reqs [$];
   rotated_pair_type expected_pairs [$];
   int               total_reqs = 0;
   int               accepted_count = 0;
   int               mismatches = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   rx_mode_type      ready_mode = RX_STEADY;
   int               mode_left = 0;
   logic             hold_active = 1'b0;
   logic             hold_done = 1'b0;
   int               hold_left = 0;

   rotary_position_rotate dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_position   (req_position),
      .req_pair_index (req_pair_index),
      .req_real_in    (req_real_in),
      .req_imag_in    (req_imag_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_real_out   (rsp_real_out),
      .rsp_imag_out   (rsp_imag_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Truncating integer square root, two bits per step.
   function automatic longint unsigned int_sqrt(input longint unsigned v_in);
      longint unsigned v;
      longint unsigned root;
      longint unsigned bit_w;
      v     = v_in;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [rpr_pkg::SAMPLE_W-1:0] saturate16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Expected rotated pair for one request: phase lookup, exact quarter turn,
   // CORDIC on the residual, gain compensation, rounding and saturation.
   function automatic rotated_pair_type rotate_pair(input rotate_req_type rq);
      rotated_pair_type     result;
      longint unsigned      pos;
      longint unsigned      idx;
      longint unsigned      wide;
      logic [31:0]          phase;
      logic [31:0]          residual;
      rpr_pkg::quarter_type quarter;
      longint               x;
      longint               y;
      longint               z;
      longint               t;
      longint               dx;
      longint               dy;
      longint               half;
      pos = rq.position;
      idx = rq.pair_index;
      if (pos >= POSITION_SPAN) pos = POSITION_SPAN - 1;
      if (idx >= PAIR_COUNT) idx = PAIR_COUNT - 1;
      phase    = 32'(pos * 64'(freq_turns[idx]));
      wide     = 64'(phase) + (64'd1 << 29);
      quarter  = rpr_pkg::quarter_type'(2'(wide >> 30));
      residual = phase - {quarter, 30'd0};
      z = $signed(residual);
      x = rq.re;
      y = rq.im;
      x = x * (64'sd1 <<< GUARD);
      y = y * (64'sd1 <<< GUARD);

      // Whole quarter turns are exact swaps and negations.
      case (quarter)
         rpr_pkg::QUARTER_LEFT: begin
            t = x;
            x = -y;
            y = t;
         end
         rpr_pkg::QUARTER_HALF: begin
            x = -x;
            y = -y;
         end
         rpr_pkg::QUARTER_RIGHT: begin
            t = x;
            x = y;
            y = -t;
         end
         default: begin
         end
      endcase

      // Drive the residual angle to zero.
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - step_angle[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + step_angle[i];
         end
      end

      half = 64'sd1 <<< (GAIN_BITS + GUARD - 1);
      result.re = saturate16((x * cordic_gain + half) >>> (GAIN_BITS + GUARD));
      result.im = saturate16((y * cordic_gain + half) >>> (GAIN_BITS + GUARD));
      return result;
   endfunction

   function automatic void queue_req(input logic [rpr_pkg::POS_W-1:0] pos,
                                     input logic [rpr_pkg::PAIR_W-1:0] idx,
                                     input logic signed [rpr_pkg::SAMPLE_W-1:0] re,
                                     input logic signed [rpr_pkg::SAMPLE_W-1:0] im);
      rotate_req_type rq;
      rq.position   = pos;
      rq.pair_index = idx;
      rq.re         = re;
      rq.im         = im;
      pending_reqs.push_back(rq);
   endfunction

   // Samples lean toward the extremes and small magnitudes.
   function automatic logic signed [rpr_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($signed($urandom_range(0, 512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // Inverse frequencies, step angles and gain of the predictor.
   initial begin : build_tables
      longint unsigned ladder [32];
      longint unsigned expo;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned r;
      longint unsigned rad;
      longint unsigned g;
      longint unsigned arg;
      longint          sum;
      longint          term;
      ladder[0] = int_sqrt(64'd1 << 63);
      for (int b = 1; b < 32; b++) ladder[b] = int_sqrt(ladder[b-1] << 32);
      for (int k = 0; k < PAIR_COUNT; k++) begin
         expo  = (64'(2 * k) * LOG2_THETA) / 64'(HEAD_SIZE);
         whole = expo >> 32;
         frac  = expo & 64'hffff_ffff;
         r     = 64'd1 << 32;
         for (int b = 1; b <= 32; b++) begin
            if (((frac >> (32 - b)) & 64'd1) != 0) r = (r * ladder[b-1]) >> 32;
         end
         r = (whole < 63) ? (r >> whole) : 64'd0;
         freq_turns[k] = 32'((r * TURN_SCALE + (64'd1 << 31)) >> 32);
      end

      // atan(2^-i) from its power series, then converted to turns.
      step_angle[0] = 64'sd1 <<< 29;
      for (int i = 1; i < STAGES; i++) begin
         sum = 0;
         for (int n = 0; 62 - i * (2 * n + 1) >= 0; n++) begin
            term = (64'd1 << (62 - i * (2 * n + 1))) / 64'(2 * n + 1);
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         rad = sum;
         rad = (rad + (64'd1 << 29)) >> 30;
         step_angle[i] = (rad * TURN_SCALE + (64'd1 << 31)) >> 32;
      end

      g = 64'd1 << 30;
      for (int i = 0; i < STAGES; i++) begin
         arg = (64'd1 << 30) + ((30 - 2 * i >= 0) ? (64'd1 << (30 - 2 * i)) : 64'd0);
         g   = (g << 30) / int_sqrt(arg << 30);
      end
      cordic_gain = g;
   end

   // Request stream, reset and end of run.
   initial begin : run
      logic [rpr_pkg::POS_W-1:0]  pos;
      logic [rpr_pkg::PAIR_W-1:0] idx;

      // Directed requests: no rotation, every quarter turn, saturation,
      // extreme positions and pair indexes, and full-scale samples.
      queue_req(0, 0, 16'sh7fff, 16'sh8000);
      queue_req(0, 0, 16'sh8000, 16'sh7fff);
      queue_req(0, 0, 0, 16'sh7fff);
      queue_req(0, 63, 1, -1);
      queue_req(1, 0, 4096, 0);
      queue_req(2, 0, 4096, 4096);
      queue_req(3, 0, -4096, 8192);
      queue_req(5, 0, 12345, -2222);
      queue_req(1, 0, 16'sh7fff, 16'sh7fff);
      queue_req(1, 0, 16'sh8000, 16'sh8000);
      queue_req(4, 0, 16'sh7fff, 16'sh8000);
      queue_req(4095, 63, 16'sh7fff, 16'sh7fff);
      queue_req(4095, 0, 16'sh8000, 16'sh8000);
      queue_req(4095, 63, 0, 0);
      queue_req(4095, 31, 16'sh8000, 16'sh8000);
      queue_req(2048, 32, -1, -1);
      queue_req(7, 1, 30000, -30000);
      queue_req(100, 10, 16'sh8000, 0);
      queue_req(1, 63, 16'sh7fff, 16'sh8000);
      queue_req(2730, 5, -20000, 25000);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         case ($urandom_range(0, 7))
            0: pos = '0;
            1: pos = '1;
            2: pos = rpr_pkg::POS_W'($urandom_range(1, 16));
            default: pos = rpr_pkg::POS_W'($urandom);
         endcase
         if ($urandom_range(0, 7) == 0) idx = ($urandom_range(0, 1) == 1) ? '1 : '0;
         else idx = rpr_pkg::PAIR_W'($urandom);
         queue_req(pos, idx, pick_sample(), pick_sample());
      end
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_reqs) @(posedge clock);
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Driver: bursts of requests separated by random gaps. Gaps are skipped
   // while the receiver holds off so that the pipeline fills up.
   always @(posedge clock) begin : drive_req
      rotate_req_type staged;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 && !hold_active) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            staged = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_position   <= staged.position;
            req_pair_index <= staged.pair_index;
            req_real_in    <= staged.re;
            req_imag_in    <= staged.im;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: a stall pattern that switches between randomly chosen modes.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_mode <= RX_STEADY;
         mode_left  <= 0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= rx_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_active) begin
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= !rsp_ready;
            endcase
         end
      end
   end

   // One long receiver hold-off, started once enough requests have gone in.
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_done   <= 1'b0;
         hold_left   <= 0;
      end else if (hold_active) begin
         if (hold_left <= 1) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b1;
         end
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         hold_active <= 1'b1;
         hold_left   <= HOLD_CYCLES;
      end
   end

   // Monitor: predicts each accepted request and checks each response
   // against the oldest prediction. Later mismatches are counted but not
   // printed, to keep the log short.
   always @(posedge clock) begin : check_rsp
      rotated_pair_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: response with none expected: real %0d imag %0d",
                           $time, rsp_real_out, rsp_imag_out);
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_real_out !== want.re) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: real_out mismatch: expected %0d, actual %0d",
                              $time, want.re, rsp_real_out);
                  mismatches++;
               end
               if (rsp_imag_out !== want.im) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: imag_out mismatch: expected %0d, actual %0d",
                              $time, want.im, rsp_imag_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_pairs.push_back(rotate_pair({req_position, req_pair_index,
                                                  req_real_in, req_imag_in}));
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // Timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d requests accepted", $time, accepted_count);
         $display("FAIL");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/rpr_pkg.sv
rtl/rpr_cell.sv
rtl/rpr_gain.sv
rtl/rotary_position_rotate.sv
bench/testbench.sv
